FILE: hdl/cpcf_pkg.sv
// Shared types and constants for the convex polygon contact finder.
// No dependencies; used by the top level and the testbench.
`timescale 1ns / 1ps
package cpcf_pkg;

  // Fraction bits of the intersection ratio
  localparam int T_FRAC = 30;
  localparam int TQ_W   = T_FRAC + 1;

  typedef enum logic [1:0] {
    OP_LOAD_VERTEX = 2'd0,
    OP_LOAD_REF    = 2'd1,
    OP_FIND        = 2'd2
  } op_t;

  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
  } pt_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic               polygon;
    logic [3:0]         slot;
    logic               final_vertex;
    logic signed [23:0] coord_x;
    logic signed [23:0] coord_y;
  } in_req_t;

  typedef struct packed {
    logic               found;
    logic               from_polygon;
    logic [3:0]         point_index;
    logic [3:0]         edge_index;
    logic signed [23:0] contact_x;
    logic signed [23:0] contact_y;
    logic               last;
  } out_res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_VSTART,
    ST_VREAD,
    ST_EREAD,
    ST_MUL,
    ST_CHECK,
    ST_DIV,
    ST_SCALE,
    ST_ENEXT,
    ST_PUSH,
    ST_FLUSH
  } state_t;

endpackage

FILE: hdl/convex_polygon_contact_finder_top.sv
// Convex polygon contact finder: vertex stores, edge walk sequencer, result queue.
// Depends on cpcf_pkg and cpcf_ram.
`timescale 1ns / 1ps
// Load requests (vertex or reference point) are handled in the idle state. A find
// request walks vertex 0.. of A against the edges of B, then B against A, with one
// vertex read per vertex and one edge endpoint read per edge from the vertex RAMs.
// Each edge tested passes through the shared multiplier; an edge that is hit then
// runs the bit-serial ratio divider and the shared multiplier again to place the
// point and measure its distance. A vertex found outside stops at the first failing
// edge. Contacts leave in discovery order through a one-deep pending stage and an
// output register, the last one flagged; with no contact a single result with found
// clear is sent. No other request is taken until the last result of a find sits in
// the output register.
module convex_polygon_contact_finder_top #(
  parameter int MAX_VERTS    = 16,
  parameter int MAX_CONTACTS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  cpcf_pkg::in_req_t in_req,
  output logic              out_valid,
  input  logic              out_stall,
  output cpcf_pkg::out_res_t out_res
);

  localparam int VW = $clog2(MAX_VERTS);
  localparam int CW = $clog2(MAX_VERTS + 1);
  localparam int NW = $clog2(MAX_CONTACTS + 1);
  localparam int DCW = $clog2(cpcf_pkg::T_FRAC + 1);

  cpcf_pkg::state_t state_r, state_nxt;

  // Control registers
  logic          side_r;
  logic [CW-1:0] vi_r, ei_r;
  logic [NW-1:0] ncont_r;
  logic [2:0]    stp_r;
  logic [DCW-1:0] dcnt_r;
  logic          inside_r, full_r;
  logic          best_valid_r, pend_valid_r, out_valid_r;
  logic [CW-1:0] count_a_r, count_b_r;
  cpcf_pkg::pt_t ref_a_r, ref_b_r;

  // Datapath registers
  cpcf_pkg::pt_t vert_r, first_r, s_r, q_r;
  logic signed [24:0] a_r, c_r, b_r, d_r, ex_r, fy_r, dx_r, dy_r;
  logic signed [51:0] k_r, tn_r, un_r;
  logic signed [63:0] prod_r;
  logic [51:0]        rem_r;
  logic [51:0]        dk_r;
  logic [cpcf_pkg::TQ_W-1:0] tq_r;
  logic signed [23:0] cpx_r, cpy_r;
  logic [49:0]        dsum_r;
  logic [50:0]        best_d_r;
  logic [CW-1:0]      best_e_r;
  logic signed [23:0] best_x_r, best_y_r;
  cpcf_pkg::out_res_t pend_r, out_r;

  // Memory ports
  logic          we_a, we_b;
  logic [VW-1:0] waddr, own_addr, oth_addr, raddr_a, raddr_b;
  logic [47:0]   rd_a, rd_b;
  cpcf_pkg::pt_t own_rd, oth_rd, ref_sel, q_sel;
  logic [CW-1:0] no, nt;

  // Shared multiplier operands
  logic signed [31:0] mul_a, mul_b;

  logic in_acc, out_free, load_out, vdone, e_last, is_hit;
  logic [CW:0] eadd2;
  logic signed [51:0] kn, tnn, unn;
  logic [52:0] rem2;
  logic [50:0] dnew;
  cpcf_pkg::out_res_t res_new, res_last;

  function automatic logic signed [25:0] trunc_q(input logic signed [63:0] p);
    logic [63:0] mag;
    logic [63:0] sh;
    mag = p[63] ? 64'(-p) : 64'(p);
    sh = mag >> cpcf_pkg::T_FRAC;
    trunc_q = p[63] ? -$signed(26'(sh)) : $signed(26'(sh));
  endfunction

  cpcf_ram #(.WIDTH(48), .DEPTH(MAX_VERTS)) u_ram_a (
    .clk(clk), .we(we_a), .waddr(waddr), .wdata(48'({in_req.coord_x, in_req.coord_y})),
    .raddr(raddr_a), .rdata(rd_a)
  );

  cpcf_ram #(.WIDTH(48), .DEPTH(MAX_VERTS)) u_ram_b (
    .clk(clk), .we(we_b), .waddr(waddr), .wdata(48'({in_req.coord_x, in_req.coord_y})),
    .raddr(raddr_b), .rdata(rd_b)
  );

  // Steer own and other polygon views
  always_comb begin
    own_rd  = side_r ? cpcf_pkg::pt_t'(rd_b) : cpcf_pkg::pt_t'(rd_a);
    oth_rd  = side_r ? cpcf_pkg::pt_t'(rd_a) : cpcf_pkg::pt_t'(rd_b);
    no      = side_r ? count_b_r : count_a_r;
    nt      = side_r ? count_a_r : count_b_r;
    ref_sel = side_r ? ref_b_r : ref_a_r;
    in_acc  = in_valid && !in_stall;
    out_free = !out_valid_r || !out_stall;
    vdone   = (vi_r >= no) || (ncont_r == NW'(MAX_CONTACTS));
    e_last  = ((ei_r + CW'(1)) == nt);
    eadd2   = (CW+1)'(ei_r) + (CW+1)'(2);
    q_sel   = e_last ? first_r : oth_rd;
    // Normalize so the determinant is positive
    kn  = k_r[51] ? -k_r : k_r;
    tnn = k_r[51] ? -tn_r : tn_r;
    unn = k_r[51] ? -un_r : un_r;
    is_hit = (k_r != '0) && !tnn[51] && (tnn <= kn) && !unn[51] && (unn <= kn);
    rem2 = {rem_r, 1'b0};
    dnew = 51'(dsum_r) + 51'(prod_r[49:0]);
    load_out = out_free && ((state_r == cpcf_pkg::ST_PUSH && pend_valid_r)
                            || state_r == cpcf_pkg::ST_FLUSH);
    res_new.found        = 1'b1;
    res_new.from_polygon = side_r;
    res_new.point_index  = 4'(vi_r);
    res_new.edge_index   = 4'(best_e_r);
    res_new.contact_x    = best_x_r;
    res_new.contact_y    = best_y_r;
    res_new.last         = 1'b0;
    // Final result of a find: pending contact or the no-contact result
    res_last      = pend_valid_r ? pend_r : '0;
    res_last.last = 1'b1;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cpcf_pkg::ST_IDLE: begin
        if (in_acc && in_req.operation == cpcf_pkg::OP_FIND) state_nxt = cpcf_pkg::ST_VSTART;
      end
      cpcf_pkg::ST_VSTART: begin
        if (!vdone) state_nxt = cpcf_pkg::ST_VREAD;
        else if (side_r) state_nxt = cpcf_pkg::ST_FLUSH;
      end
      cpcf_pkg::ST_VREAD: state_nxt = (nt == '0) ? cpcf_pkg::ST_VSTART : cpcf_pkg::ST_EREAD;
      cpcf_pkg::ST_EREAD: state_nxt = cpcf_pkg::ST_MUL;
      cpcf_pkg::ST_MUL: begin
        if (stp_r == 3'd6) state_nxt = cpcf_pkg::ST_CHECK;
      end
      cpcf_pkg::ST_CHECK: begin
        if (tn_r > 0) state_nxt = cpcf_pkg::ST_VSTART;
        else if (is_hit) state_nxt = cpcf_pkg::ST_DIV;
        else state_nxt = cpcf_pkg::ST_ENEXT;
      end
      cpcf_pkg::ST_DIV: begin
        if (dcnt_r == DCW'(cpcf_pkg::T_FRAC - 1)) state_nxt = cpcf_pkg::ST_SCALE;
      end
      cpcf_pkg::ST_SCALE: begin
        if (stp_r == 3'd5) state_nxt = cpcf_pkg::ST_ENEXT;
      end
      cpcf_pkg::ST_ENEXT: begin
        if (!e_last) state_nxt = cpcf_pkg::ST_EREAD;
        else if (best_valid_r) state_nxt = cpcf_pkg::ST_PUSH;
        else state_nxt = cpcf_pkg::ST_VSTART;
      end
      cpcf_pkg::ST_PUSH: begin
        if (!pend_valid_r || out_free) state_nxt = cpcf_pkg::ST_VSTART;
      end
      cpcf_pkg::ST_FLUSH: begin
        if (out_free) state_nxt = cpcf_pkg::ST_IDLE;
      end
      default: state_nxt = cpcf_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: handshake, memory addresses, multiplier operands
  always_comb begin
    in_stall = (state_r != cpcf_pkg::ST_IDLE);
    waddr    = VW'(in_req.slot);
    we_a     = 1'b0;
    we_b     = 1'b0;
    if (in_acc && in_req.operation == cpcf_pkg::OP_LOAD_VERTEX
        && 32'(in_req.slot) < MAX_VERTS) begin
      we_a = !in_req.polygon;
      we_b = in_req.polygon;
    end
    own_addr = VW'(vi_r);
    oth_addr = '0;
    mul_a    = '0;
    mul_b    = '0;
    unique case (state_r)
      cpcf_pkg::ST_VREAD: oth_addr = (nt > CW'(1)) ? VW'(1) : '0;
      cpcf_pkg::ST_ENEXT: oth_addr = (eadd2 < (CW+1)'(nt)) ? VW'(eadd2) : '0;
      cpcf_pkg::ST_MUL: begin
        case (stp_r)
          3'd0: begin mul_a = 32'(a_r); mul_b = 32'(d_r);  end
          3'd1: begin mul_a = 32'(b_r); mul_b = 32'(c_r);  end
          3'd2: begin mul_a = 32'(d_r); mul_b = 32'(ex_r); end
          3'd3: begin mul_a = 32'(b_r); mul_b = 32'(fy_r); end
          3'd4: begin mul_a = 32'(a_r); mul_b = 32'(fy_r); end
          3'd5: begin mul_a = 32'(c_r); mul_b = 32'(ex_r); end
          default: ;
        endcase
      end
      cpcf_pkg::ST_SCALE: begin
        case (stp_r)
          3'd0: begin mul_a = $signed(32'(tq_r)); mul_b = 32'(a_r); end
          3'd1: begin mul_a = $signed(32'(tq_r)); mul_b = 32'(c_r); end
          3'd3: begin mul_a = 32'(dx_r); mul_b = 32'(dx_r); end
          3'd4: begin mul_a = 32'(dy_r); mul_b = 32'(dy_r); end
          default: ;
        endcase
      end
      default: ;
    endcase
    raddr_a = side_r ? oth_addr : own_addr;
    raddr_b = side_r ? own_addr : oth_addr;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= cpcf_pkg::ST_IDLE;
      side_r       <= 1'b0;
      vi_r         <= '0;
      ei_r         <= '0;
      ncont_r      <= '0;
      stp_r        <= '0;
      dcnt_r       <= '0;
      inside_r     <= 1'b0;
      full_r       <= 1'b0;
      best_valid_r <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      count_a_r    <= '0;
      count_b_r    <= '0;
      ref_a_r      <= '0;
      ref_b_r      <= '0;
    end else begin
      state_r <= state_nxt;
      // Hold the output until taken
      if (load_out) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      case (state_r)
        cpcf_pkg::ST_IDLE: begin
          if (in_acc) begin
            case (in_req.operation)
              cpcf_pkg::OP_LOAD_VERTEX: begin
                if (32'(in_req.slot) < MAX_VERTS && in_req.final_vertex) begin
                  if (in_req.polygon) count_b_r <= CW'(in_req.slot) + CW'(1);
                  else count_a_r <= CW'(in_req.slot) + CW'(1);
                end
              end
              cpcf_pkg::OP_LOAD_REF: begin
                if (in_req.polygon) ref_b_r <= {in_req.coord_x, in_req.coord_y};
                else ref_a_r <= {in_req.coord_x, in_req.coord_y};
              end
              cpcf_pkg::OP_FIND: begin
                side_r  <= 1'b0;
                vi_r    <= '0;
                ncont_r <= '0;
              end
              default: ;
            endcase
          end
        end
        cpcf_pkg::ST_VSTART: begin
          ei_r         <= '0;
          inside_r     <= 1'b1;
          best_valid_r <= 1'b0;
          if (vdone && !side_r) begin
            side_r <= 1'b1;
            vi_r   <= '0;
          end
        end
        cpcf_pkg::ST_VREAD: begin
          if (nt == '0) vi_r <= vi_r + CW'(1);
        end
        cpcf_pkg::ST_EREAD: stp_r <= '0;
        cpcf_pkg::ST_MUL: stp_r <= stp_r + 3'd1;
        cpcf_pkg::ST_CHECK: begin
          dcnt_r <= '0;
          stp_r  <= '0;
          full_r <= (tnn == kn);
          if (tn_r > 0) begin
            inside_r <= 1'b0;
            vi_r     <= vi_r + CW'(1);
          end
        end
        cpcf_pkg::ST_DIV: dcnt_r <= dcnt_r + DCW'(1);
        cpcf_pkg::ST_SCALE: begin
          stp_r <= stp_r + 3'd1;
          if (stp_r == 3'd5 && (!best_valid_r || dnew < best_d_r)) best_valid_r <= 1'b1;
        end
        cpcf_pkg::ST_ENEXT: begin
          ei_r <= ei_r + CW'(1);
          if (e_last && !best_valid_r) vi_r <= vi_r + CW'(1);
        end
        cpcf_pkg::ST_PUSH: begin
          if (!pend_valid_r || out_free) begin
            pend_valid_r <= 1'b1;
            ncont_r      <= ncont_r + NW'(1);
            vi_r         <= vi_r + CW'(1);
          end
        end
        cpcf_pkg::ST_FLUSH: begin
          if (out_free) pend_valid_r <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (load_out) begin
      if (state_r == cpcf_pkg::ST_PUSH) begin
        out_r <= pend_r;
      end else begin
        out_r <= res_last;
      end
    end
    case (state_r)
      cpcf_pkg::ST_VREAD: begin
        vert_r  <= own_rd;
        first_r <= oth_rd;
        s_r     <= oth_rd;
      end
      cpcf_pkg::ST_EREAD: begin
        // Register all differences for this edge
        q_r  <= q_sel;
        a_r  <= 25'(ref_sel.x) - 25'(vert_r.x);
        c_r  <= 25'(ref_sel.y) - 25'(vert_r.y);
        b_r  <= 25'(s_r.x) - 25'(q_sel.x);
        d_r  <= 25'(s_r.y) - 25'(q_sel.y);
        ex_r <= 25'(s_r.x) - 25'(vert_r.x);
        fy_r <= 25'(s_r.y) - 25'(vert_r.y);
      end
      cpcf_pkg::ST_MUL: begin
        case (stp_r)
          3'd1: k_r  <= 52'(prod_r);
          3'd2: k_r  <= k_r - 52'(prod_r);
          3'd3: tn_r <= 52'(prod_r);
          3'd4: tn_r <= tn_r - 52'(prod_r);
          3'd5: un_r <= 52'(prod_r);
          3'd6: un_r <= un_r - 52'(prod_r);
          default: ;
        endcase
      end
      cpcf_pkg::ST_CHECK: begin
        rem_r <= $unsigned(tnn);
        dk_r  <= $unsigned(kn);
        tq_r  <= '0;
      end
      cpcf_pkg::ST_DIV: begin
        // One quotient bit per cycle; force the full ratio at the end
        if (dcnt_r == DCW'(cpcf_pkg::T_FRAC - 1) && full_r) begin
          tq_r <= cpcf_pkg::TQ_W'(1) << cpcf_pkg::T_FRAC;
        end else if (rem2 >= {1'b0, dk_r}) begin
          rem_r <= 52'(rem2 - {1'b0, dk_r});
          tq_r  <= {tq_r[cpcf_pkg::TQ_W-2:0], 1'b1};
        end else begin
          rem_r <= rem2[51:0];
          tq_r  <= {tq_r[cpcf_pkg::TQ_W-2:0], 1'b0};
        end
      end
      cpcf_pkg::ST_SCALE: begin
        case (stp_r)
          3'd1: cpx_r <= 24'(26'(vert_r.x) + trunc_q(prod_r));
          3'd2: begin
            cpy_r <= 24'(26'(vert_r.y) + trunc_q(prod_r));
            dx_r  <= 25'(cpx_r) - 25'(ref_sel.x);
          end
          3'd3: dy_r <= 25'(cpy_r) - 25'(ref_sel.y);
          3'd4: dsum_r <= prod_r[49:0];
          3'd5: begin
            // Keep the nearest hit; ties keep the earlier edge
            if (!best_valid_r || dnew < best_d_r) begin
              best_d_r <= dnew;
              best_e_r <= ei_r;
              best_x_r <= cpx_r;
              best_y_r <= cpy_r;
            end
          end
          default: ;
        endcase
      end
      cpcf_pkg::ST_ENEXT: s_r <= q_r;
      cpcf_pkg::ST_PUSH: begin
        if (!pend_valid_r || out_free) pend_r <= res_new;
      end
      default: ;
    endcase
  end

  // Pending contact never survives past the end of a find
  a_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cpcf_pkg::ST_IDLE) |-> !pend_valid_r)
    else $error("pending contact left in idle");

  a_ncont_max: assert property (@(posedge clk) disable iff (!rst_n)
    ncont_r <= NW'(MAX_CONTACTS))
    else $error("contact count above limit");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cpcf_pkg::ST_DIV) |-> (dk_r != '0))
    else $error("divider started with zero divisor");

  a_flush_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cpcf_pkg::ST_FLUSH && out_free) |=> (out_valid_r && out_r.last))
    else $error("final result not flagged last");

  a_inside_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cpcf_pkg::ST_DIV || state_r == cpcf_pkg::ST_SCALE) |-> inside_r)
    else $error("hit evaluated for outside vertex");

endmodule

FILE: hdl/cpcf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module cpcf_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Registered write and read; a read of the address being written returns the old data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: tb/sv/tb_convex_polygon_contact_finder_top.sv
// Testbench for the convex polygon contact finder: directed table plus random polygon scenes.
// Depends on cpcf_pkg and convex_polygon_contact_finder_top; predicts contacts internally.
`timescale 1ns / 1ps
module tb_convex_polygon_contact_finder_top;

  localparam int VERTS     = 16;
  localparam int MAX_HITS  = 8;
  localparam int RATIO_W   = 30;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam cpcf_pkg::out_res_t NO_CONTACT = '{found: 1'b0, from_polygon: 1'b0,
                                                point_index: 4'd0, edge_index: 4'd0,
                                                contact_x: 24'sd0, contact_y: 24'sd0,
                                                last: 1'b1};

  typedef struct {
    cpcf_pkg::in_req_t req;
    bit                typed;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  cpcf_pkg::in_req_t  in_req;
  logic               out_valid;
  logic               out_stall;
  cpcf_pkg::out_res_t out_res;

  // Predictor copy of the polygon stores
  longint   vert_x [2][VERTS];
  longint   vert_y [2][VERTS];
  int       vert_count [2];
  longint   ref_x [2];
  longint   ref_y [2];
  bit       slot_written [2][VERTS];

  cpcf_pkg::out_res_t contact_q [$];
  stim_row_t directed_rows [$];
  int       errors;
  int       items_sent;
  int       finds_sent;
  int       results_seen;
  int       contacts_seen;

  convex_polygon_contact_finder_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_req(in_req),
    .out_valid(out_valid), .out_stall(out_stall), .out_res(out_res)
  );

  always #5 clk = ~clk;

  function automatic cpcf_pkg::in_req_t mk_req(logic [1:0] op, logic pg, int slot, logic fin,
                                               longint x, longint y);
    cpcf_pkg::in_req_t r;
    r.operation    = op;
    r.polygon      = pg;
    r.slot         = slot[3:0];
    r.final_vertex = fin;
    r.coord_x      = x[23:0];
    r.coord_y      = y[23:0];
    return r;
  endfunction

  // A point is inside when no edge cross product is negative
  function automatic bit is_inside(longint px, longint py, int pg);
    int     nx;
    longint cx, cy, dx, dy;
    for (int e = 0; e < vert_count[pg]; e++) begin
      nx = (e + 1) % vert_count[pg];
      cx = vert_x[pg][nx] - vert_x[pg][e];
      cy = vert_y[pg][nx] - vert_y[pg][e];
      dx = px - vert_x[pg][e];
      dy = py - vert_y[pg][e];
      if (cx * dy - cy * dx < 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic longint scale_ratio(longint tq, longint delta);
    longint p;
    p = tq * delta;
    if (p < 0) return -((-p) >> RATIO_W);
    return p >> RATIO_W;
  endfunction

  // Nearest crossing of the vertex-to-reference segment with polygon pg's edges
  function automatic int nearest_edge(longint px, longint py, longint rx, longint ry, int pg,
                                      output longint hx, output longint hy);
    int      best, nx;
    longint  best_d, a, c, b, d, ex, fy, k, tn, un, tq, cx, cy, sq_dist;
    longint unsigned rem;
    best = -1;
    best_d = 0;
    hx = 0;
    hy = 0;
    for (int e = 0; e < vert_count[pg]; e++) begin
      nx = (e + 1) % vert_count[pg];
      a  = rx - px;
      c  = ry - py;
      b  = vert_x[pg][e] - vert_x[pg][nx];
      d  = vert_y[pg][e] - vert_y[pg][nx];
      ex = vert_x[pg][e] - px;
      fy = vert_y[pg][e] - py;
      k  = a * d - b * c;
      tn = d * ex - b * fy;
      un = a * fy - c * ex;
      if (k == 0) continue;
      if (k < 0) begin
        k = -k;
        tn = -tn;
        un = -un;
      end
      if (tn < 0 || tn > k || un < 0 || un > k) continue;
      // Restoring division for the Q1.30 ratio
      rem = tn;
      tq = 0;
      for (int i = 0; i < RATIO_W; i++) begin
        rem = rem << 1;
        tq  = tq << 1;
        if (rem >= longint'(k)) begin
          rem = rem - k;
          tq  = tq | 1;
        end
      end
      if (tn == k) tq = longint'(1) << RATIO_W;
      cx = px + scale_ratio(tq, a);
      cy = py + scale_ratio(tq, c);
      sq_dist = (cx - rx) * (cx - rx) + (cy - ry) * (cy - ry);
      if (best < 0 || sq_dist < best_d) begin
        best = e;
        best_d = sq_dist;
        hx = cx;
        hy = cy;
      end
    end
    return best;
  endfunction

  // Apply one accepted request to the predictor and queue the contacts it yields
  task automatic predict_request(cpcf_pkg::in_req_t r);
    cpcf_pkg::out_res_t found_q [$];
    cpcf_pkg::out_res_t res;
    longint   hx, hy;
    int       e, own, oth;
    case (r.operation)
      cpcf_pkg::OP_LOAD_VERTEX: begin
        vert_x[r.polygon][r.slot] = longint'($signed(r.coord_x));
        vert_y[r.polygon][r.slot] = longint'($signed(r.coord_y));
        if (r.final_vertex) vert_count[r.polygon] = int'(r.slot) + 1;
      end
      cpcf_pkg::OP_LOAD_REF: begin
        ref_x[r.polygon] = longint'($signed(r.coord_x));
        ref_y[r.polygon] = longint'($signed(r.coord_y));
      end
      cpcf_pkg::OP_FIND: begin
        for (own = 0; own < 2; own++) begin
          oth = 1 - own;
          for (int v = 0; v < vert_count[own] && found_q.size() < MAX_HITS; v++) begin
            if (!is_inside(vert_x[own][v], vert_y[own][v], oth)) continue;
            e = nearest_edge(vert_x[own][v], vert_y[own][v], ref_x[own], ref_y[own], oth,
                             hx, hy);
            if (e < 0) continue;
            res = '{found: 1'b1, from_polygon: own[0], point_index: v[3:0],
                    edge_index: e[3:0], contact_x: hx[23:0], contact_y: hy[23:0],
                    last: 1'b0};
            found_q = {found_q, res};
          end
        end
        if (found_q.size() == 0) found_q = {found_q, NO_CONTACT};
        found_q[found_q.size() - 1].last = 1'b1;
        contact_q = {contact_q, found_q};
      end
      default: ;
    endcase
  endtask

  // Present one request after a random gap and hold it until taken
  task automatic send_row(stim_row_t row);
    int gap;
    gap = ((items_sent / 20) % 3 == 2) ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= row.req;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (row.req.operation == cpcf_pkg::OP_LOAD_VERTEX)
      slot_written[row.req.polygon][row.req.slot] = 1'b1;
    if (row.req.operation == cpcf_pkg::OP_FIND) finds_sent++;
    if (row.typed && row.req.operation == cpcf_pkg::OP_FIND) begin
      contact_q = {contact_q, NO_CONTACT};
    end else begin
      predict_request(row.req);
    end
  endtask

  task automatic send_req(cpcf_pkg::in_req_t r);
    stim_row_t row;
    row.req = r;
    row.typed = 1'b0;
    send_row(row);
  endtask

  // Load a roughly regular polygon, either winding, ending with the count-setting vertex
  task automatic load_polygon(int pg, longint cx, longint cy, longint rad);
    int  n;
    real phase, dir, ang;
    n = ($urandom_range(0, 9) == 0) ? VERTS : $urandom_range(3, 6);
    phase = $urandom_range(0, 6283) / 1000.0;
    dir = ($urandom_range(0, 7) == 0) ? -1.0 : 1.0;
    for (int i = 0; i < n; i++) begin
      ang = phase + dir * 6.283185307 * i / n;
      send_req(mk_req(cpcf_pkg::OP_LOAD_VERTEX, pg[0], i, i == n - 1,
                      cx + $rtoi(rad * $cos(ang)), cy + $rtoi(rad * $sin(ang))));
    end
  endtask

  // Random request of any kind; a vertex count is set only over written slots
  task automatic send_noise();
    logic [1:0] op;
    logic       pg;
    int         slot;
    bit         fin;
    op   = 2'($urandom_range(0, 3));
    pg   = 1'($urandom_range(0, 1));
    slot = $urandom_range(0, VERTS - 1);
    fin  = 1'($urandom_range(0, 1));
    for (int i = 0; i < slot; i++) if (!slot_written[pg][i]) fin = 1'b0;
    send_req(mk_req(op, pg, slot, fin, longint'($signed(24'($urandom))),
                    longint'($signed(24'($urandom)))));
  endtask

  task automatic run_scene();
    longint ca_x, ca_y, cb_x, cb_y, ra, rb, span;
    int     kind;
    kind = $urandom_range(0, 5);
    ra = longint'($urandom_range(1 << 10, 1 << 20));
    rb = longint'($urandom_range(1 << 10, 1 << 20));
    span = ra + rb;
    ca_x = longint'($urandom_range(0, 1 << 21)) - (1 << 20);
    ca_y = longint'($urandom_range(0, 1 << 21)) - (1 << 20);
    cb_x = ca_x + longint'($urandom_range(0, 32'(2 * span))) - span;
    cb_y = ca_y + longint'($urandom_range(0, 32'(2 * span))) - span;
    if (kind < 3) load_polygon(0, ca_x, ca_y, ra);
    if (kind < 5) load_polygon(1, cb_x, cb_y, rb);
    // References near each center, occasionally anywhere
    if ($urandom_range(0, 4) == 0) begin
      send_req(mk_req(cpcf_pkg::OP_LOAD_REF, 1'b0, 0, 1'b0,
                      longint'($signed(24'($urandom))), longint'($signed(24'($urandom)))));
    end else begin
      send_req(mk_req(cpcf_pkg::OP_LOAD_REF, 1'b0, 0, 1'b0,
                      ca_x + longint'($urandom_range(0, 64)) - 32,
                      ca_y + longint'($urandom_range(0, 64)) - 32));
    end
    send_req(mk_req(cpcf_pkg::OP_LOAD_REF, 1'b1, 0, 1'b0, cb_x, cb_y));
    send_req(mk_req(cpcf_pkg::OP_FIND, 1'b0, 0, 1'b0, 0, 0));
    if ($urandom_range(0, 2) == 0) send_noise();
  endtask

  function automatic stim_row_t mk_row(cpcf_pkg::in_req_t r, bit typed);
    stim_row_t row;
    row.req = r;
    row.typed = typed;
    return row;
  endfunction

  function automatic void add_row(cpcf_pkg::in_req_t r, bit typed);
    directed_rows = {directed_rows, mk_row(r, typed)};
  endfunction

  function automatic void field_err(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // Stimulus: reset, directed table, random scenes, drain
  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_req    <= '0;
    errors = 0;
    items_sent = 0;
    finds_sent = 0;
    results_seen = 0;
    contacts_seen = 0;
    for (int p = 0; p < 2; p++) begin
      vert_count[p] = 0;
      ref_x[p] = 0;
      ref_y[p] = 0;
      for (int i = 0; i < VERTS; i++) begin
        vert_x[p][i] = 0;
        vert_y[p][i] = 0;
        slot_written[p][i] = 1'b0;
      end
    end
    // Empty store, unused code, extreme triangle, empty other polygon, degenerate edge
    add_row(mk_req(cpcf_pkg::OP_FIND, 1'b0, 0, 1'b0, 0, 0), 1'b1);
    add_row(mk_req(OP_UNUSED, 1'b1, 15, 1'b1, 8388607, 8388607), 1'b0);
    add_row(mk_req(cpcf_pkg::OP_LOAD_VERTEX, 1'b0, 0, 1'b0, -8388608, -8388608), 1'b0);
    add_row(mk_req(cpcf_pkg::OP_LOAD_VERTEX, 1'b0, 1, 1'b0, 8388607, -8388608), 1'b0);
    add_row(mk_req(cpcf_pkg::OP_LOAD_VERTEX, 1'b0, 2, 1'b1, 0, 8388607), 1'b0);
    add_row(mk_req(cpcf_pkg::OP_FIND, 1'b0, 0, 1'b0, 0, 0), 1'b1);
    add_row(mk_req(cpcf_pkg::OP_LOAD_VERTEX, 1'b1, 0, 1'b0, -256, -256), 1'b0);
    add_row(mk_req(cpcf_pkg::OP_LOAD_VERTEX, 1'b1, 1, 1'b0, 256, -256), 1'b0);
    add_row(mk_req(cpcf_pkg::OP_LOAD_VERTEX, 1'b1, 2, 1'b1, 0, 256), 1'b0);
    add_row(mk_req(cpcf_pkg::OP_FIND, 1'b0, 0, 1'b0, 0, 0), 1'b0);
    add_row(mk_req(cpcf_pkg::OP_LOAD_REF, 1'b1, 0, 1'b0, 8388607, 8388607), 1'b0);
    add_row(mk_req(cpcf_pkg::OP_FIND, 1'b0, 0, 1'b0, 0, 0), 1'b0);
    add_row(mk_req(cpcf_pkg::OP_LOAD_REF, 1'b0, 0, 1'b0, -8388608, 8388607), 1'b0);
    add_row(mk_req(cpcf_pkg::OP_LOAD_VERTEX, 1'b1, 3, 1'b1, 0, 256), 1'b0);
    add_row(mk_req(cpcf_pkg::OP_FIND, 1'b1, 0, 1'b0, 0, 0), 1'b0);
    add_row(mk_req(cpcf_pkg::OP_LOAD_VERTEX, 1'b1, 15, 1'b0, 1, -1), 1'b0);
    add_row(mk_req(cpcf_pkg::OP_FIND, 1'b0, 0, 1'b0, 0, 0), 1'b0);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed_rows[i]) send_row(directed_rows[i]);
    // Hold off until every pending contact has drained
    in_valid <= 1'b0;
    while (contact_q.size() != 0) @(posedge clk);
    while (items_sent < 110) run_scene();
    in_valid <= 1'b0;
    while (contact_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Sent %0d requests with %0d finds; checked %0d results, %0d of them contacts.",
             items_sent, finds_sent, results_seen, contacts_seen);
    if (errors == 0) begin
      $display("convex_polygon_contact_finder_top test passed");
    end else begin
      $display("convex_polygon_contact_finder_top test failed");
    end
    $finish;
  end

  // Result side: random stalls, compare against the oldest pending contact
  initial begin
    int                 hold;
    cpcf_pkg::out_res_t want;
    out_stall <= 1'b0;
    @(posedge rst_n);
    forever begin
      hold = ((results_seen / 10) % 3 == 1) ? 0 : $urandom_range(0, 11);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      results_seen++;
      if (out_res.found) contacts_seen++;
      if (contact_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, out_res);
        errors++;
      end else begin
        want = contact_q.pop_front();
        field_err("found", want.found, out_res.found);
        field_err("from_polygon", want.from_polygon, out_res.from_polygon);
        field_err("point_index", want.point_index, out_res.point_index);
        field_err("edge_index", want.edge_index, out_res.edge_index);
        field_err("contact_x", $signed(want.contact_x), $signed(out_res.contact_x));
        field_err("contact_y", $signed(want.contact_y), $signed(out_res.contact_y));
        field_err("last", want.last, out_res.last);
      end
    end
  end

  // Watchdog
  initial begin
    #200ms;
    $display("convex_polygon_contact_finder_top test failed");
    $finish;
  end

endmodule
